### rtl/qrk_pkg.sv
// shared types, constants and helper functions of the quaternion rk4 propagator
`timescale 1ns / 1ps
package qrk_pkg;

    localparam int STEP_FRAC_BITS = 24;
    localparam logic [23:0] STEP_SIZE_RESET = 24'd1677722;
    localparam logic [10:0] SUBSTEP_RESET = 11'd1;
    localparam logic [10:0] MAX_SUBSTEPS = 11'd1024;
    localparam logic [3:0] LAST_TERM = 4'd11;

    localparam logic CFG_STEP_SIZE = 1'b0;
    localparam logic CFG_SUBSTEP_COUNT = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE,
        S_HMUL,
        S_HRND,
        S_SUBCHK,
        S_DMUL,
        S_DRND,
        S_DACC,
        S_UPD,
        S_DIVS,
        S_DIVW,
        S_NMUL,
        S_NACC,
        S_SQS,
        S_SQW,
        S_ODIVS,
        S_ODIVW,
        S_DONE
    } state_t;

    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [63:0] den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quo;
    } div_rsp_t;

    // quaternion component feeding product term i
    function automatic logic [1:0] term_y(input logic [3:0] i);
        logic [1:0] r;
        case (i)
            4'd0:    r = 2'd1;
            4'd1:    r = 2'd2;
            4'd2:    r = 2'd3;
            4'd3:    r = 2'd0;
            4'd4:    r = 2'd2;
            4'd5:    r = 2'd3;
            4'd6:    r = 2'd0;
            4'd7:    r = 2'd1;
            4'd8:    r = 2'd3;
            4'd9:    r = 2'd0;
            4'd10:   r = 2'd1;
            4'd11:   r = 2'd2;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    // rate axis feeding product term i
    function automatic logic [1:0] term_w(input logic [3:0] i);
        logic [1:0] r;
        case (i)
            4'd0:    r = 2'd0;
            4'd1:    r = 2'd1;
            4'd2:    r = 2'd2;
            4'd3:    r = 2'd0;
            4'd4:    r = 2'd2;
            4'd5:    r = 2'd1;
            4'd6:    r = 2'd1;
            4'd7:    r = 2'd2;
            4'd8:    r = 2'd0;
            4'd9:    r = 2'd2;
            4'd10:   r = 2'd1;
            4'd11:   r = 2'd0;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic term_neg(input logic [3:0] i);
        logic r;
        case (i)
            4'd0, 4'd1, 4'd2, 4'd5, 4'd7, 4'd11: r = 1'b1;
            default:                             r = 1'b0;
        endcase
        return r;
    endfunction

    // derivative component that product term i adds into
    function automatic logic [1:0] term_k(input logic [3:0] i);
        logic [1:0] r;
        case (i)
            4'd0, 4'd1, 4'd2:  r = 2'd0;
            4'd3, 4'd4, 4'd5:  r = 2'd1;
            4'd6, 4'd7, 4'd8:  r = 2'd2;
            4'd9, 4'd10, 4'd11: r = 2'd3;
            default:           r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

### rtl/qrk_mul.sv
// shared signed 33x33 multiplier with registered product
`timescale 1ns / 1ps
module qrk_mul (
    input  logic               clk,
    input  logic signed [32:0] a,
    input  logic signed [32:0] b,
    output logic signed [65:0] prod
);

    logic signed [65:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule

### rtl/qrk_div.sv
// shared 64-bit unsigned restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module qrk_div (
    input  logic              clk,
    input  logic              rst_n,
    input  qrk_pkg::div_req_t req,
    output qrk_pkg::div_rsp_t rsp
);

    logic [64:0] rem_reg, rem_next;
    logic [63:0] quo_reg, quo_next;
    logic [63:0] den_reg, den_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [64:0] trial;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[63:0], quo_reg[63]};
        if (req.start)
        begin
            rem_next  = '0;
            quo_next  = req.num;
            den_next  = req.den;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = trial - {1'b0, den_reg};
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

### rtl/qrk_sqrt.sv
// iterative 64-bit integer square root, two radicand bits per cycle
`timescale 1ns / 1ps
module qrk_sqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] x,
    output logic        done,
    output logic [31:0] root
);

    logic [63:0] x_reg, x_next;
    logic [63:0] res_reg, res_next;
    logic [63:0] bit_reg, bit_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [64:0] cand;

    always_comb
    begin
        x_next    = x_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        cand      = {1'b0, res_reg} + {1'b0, bit_reg};
        if (start)
        begin
            x_next    = x;
            res_next  = '0;
            bit_next  = 64'h4000_0000_0000_0000;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if ({1'b0, x_reg} >= cand)
            begin
                x_next   = x_reg - cand[63:0];
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (bit_reg[0])
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign done = done_reg;
    assign root = res_reg[31:0];

endmodule

### rtl/quaternion_rk4_propagator_core.sv
// top level: sequencer and datapath of the quaternion rk4 propagator
//
//  channel | signals                              | direction
//  in      | in_valid/in_ready, quat_*, rate_*    | into block
//  out     | out_valid/out_ready, out_*, norm_zero| out of block
//  cfg     | cfg_we, cfg_index, cfg_data          | into block, no wait
//
// in_ready returns after S substeps and the normalizing, S = substeps (max 1024),
// with the output divides skipped on a zero norm
// a substep is 48 product terms through multiply, round and accumulate states on the
// shared multiplier, 16 component updates and 4 divides by six (4-bit compare and
// subtract steps); normalizing adds a square root and 4 divides on the shared divider
// in_ready is high only while idle; a result waits in the output register
`timescale 1ns / 1ps
module quaternion_rk4_propagator_core #(
    parameter int QUAT_FRAC_BITS = 30,
    parameter int RATE_FRAC_BITS = 24
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [23:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] quat_s,
    input  logic signed [31:0] quat_x,
    input  logic signed [31:0] quat_y,
    input  logic signed [31:0] quat_z,
    input  logic signed [31:0] rate_x,
    input  logic signed [31:0] rate_y,
    input  logic signed [31:0] rate_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] out_s,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y,
    output logic signed [31:0] out_z,
    output logic               norm_zero
);

    qrk_pkg::state_t state_reg, state_next;

    logic [3:0]  idx_reg, idx_next;
    logic [1:0]  stage_reg, stage_next;
    logic [10:0] sub_reg, sub_next;
    logic [23:0] step_reg, step_next;
    logic [10:0] count_reg, count_next;

    logic signed [31:0] q_reg [4];
    logic signed [31:0] q_next [4];
    logic signed [31:0] t_reg [4];
    logic signed [31:0] t_next [4];
    logic signed [31:0] rate_reg [3];
    logic signed [31:0] rate_next [3];
    logic signed [32:0] hw_reg [3];
    logic signed [32:0] hw_next [3];
    logic signed [63:0] kcur_reg [4];
    logic signed [63:0] kcur_next [4];
    logic signed [63:0] acc_reg [4];
    logic signed [63:0] acc_next [4];
    logic signed [63:0] term_reg, term_next;
    logic [64:0]        n2_reg, n2_next;
    logic [31:0]        root_reg, root_next;
    logic [31:0]        res_reg [4];
    logic [31:0]        res_next [4];
    logic               zero_reg, zero_next;

    logic [63:0]        d6_quo_reg, d6_quo_next;
    logic [2:0]         d6_rem_reg, d6_rem_next;
    logic [3:0]         d6_cnt_reg, d6_cnt_next;
    logic [6:0]         d6_rr;
    logic [3:0]         d6_digit;
    logic [6:0]         d6_sub;
    logic [6:0]         d6_left;
    logic [63:0]        d6_quo_step;

    logic [31:0] out_s_reg, out_s_next;
    logic [31:0] out_x_reg, out_x_next;
    logic [31:0] out_y_reg, out_y_next;
    logic [31:0] out_z_reg, out_z_next;
    logic        norm_zero_reg, norm_zero_next;
    logic        out_valid_reg, out_valid_next;

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod;
    logic signed [65:0] hw_round, term_round;
    qrk_pkg::div_req_t  div_req;
    qrk_pkg::div_rsp_t  div_rsp;
    logic               sqrt_start;
    logic [63:0]        sqrt_x;
    logic               sqrt_done;
    logic [31:0]        sqrt_root;

    logic [1:0]         cidx;
    logic [1:0]         tsel;
    logic signed [63:0] kc, khalf, qext, delta;
    logic [31:0]        qmag;
    logic [63:0]        qt;
    logic               out_free;

    qrk_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    qrk_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    qrk_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .x     (sqrt_x),
        .done  (sqrt_done),
        .root  (sqrt_root)
    );

    assign cidx     = idx_reg[1:0];
    assign tsel     = qrk_pkg::term_k(idx_reg);
    assign out_free = !out_valid_reg || out_ready;
    assign kc       = kcur_reg[cidx];
    assign khalf    = (kc + 64'sd1) >>> 1;
    assign qext     = {{32{q_reg[cidx][31]}}, q_reg[cidx]};
    assign qmag     = q_reg[cidx][31] ? (32'd0 - q_reg[cidx]) : q_reg[cidx];
    assign qt       = (div_rsp.quo > 64'h8000_0000) ? 64'h8000_0000 : div_rsp.quo;
    assign delta    = acc_reg[cidx][63] ? ~d6_quo_step : d6_quo_step;
    assign hw_round = (prod + (66'sd1 <<< (qrk_pkg::STEP_FRAC_BITS - 1)))
                      >>> qrk_pkg::STEP_FRAC_BITS;
    assign term_round = (prod + (66'sd1 <<< RATE_FRAC_BITS)) >>> (RATE_FRAC_BITS + 1);

    // divide by six, four quotient bits per cycle
    assign d6_rr = {d6_rem_reg, d6_quo_reg[63:60]};

    always_comb
    begin
        d6_digit = '0;
        for (int k = 1; k < 16; k++)
            if ({1'b0, d6_rr} >= 8'(6 * k))
                d6_digit = 4'(k);
    end

    assign d6_sub      = {1'b0, d6_digit, 2'b00} + {2'b00, d6_digit, 1'b0};
    assign d6_left     = d6_rr - d6_sub;
    assign d6_quo_step = {d6_quo_reg[59:0], d6_digit};

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            qrk_pkg::S_IDLE:   if (in_valid) state_next = qrk_pkg::S_HMUL;
            qrk_pkg::S_HMUL:   state_next = qrk_pkg::S_HRND;
            qrk_pkg::S_HRND:
                state_next = (idx_reg == 4'd2) ? qrk_pkg::S_SUBCHK : qrk_pkg::S_HMUL;
            qrk_pkg::S_SUBCHK:
                state_next = (sub_reg == 11'd0) ? qrk_pkg::S_NMUL : qrk_pkg::S_DMUL;
            qrk_pkg::S_DMUL:   state_next = qrk_pkg::S_DRND;
            qrk_pkg::S_DRND:   state_next = qrk_pkg::S_DACC;
            qrk_pkg::S_DACC:
                state_next = (idx_reg == qrk_pkg::LAST_TERM) ? qrk_pkg::S_UPD
                                                             : qrk_pkg::S_DMUL;
            qrk_pkg::S_UPD:
            begin
                if (idx_reg == 4'd3)
                    state_next = (stage_reg == 2'd3) ? qrk_pkg::S_DIVS : qrk_pkg::S_DMUL;
            end
            qrk_pkg::S_DIVS:   state_next = qrk_pkg::S_DIVW;
            qrk_pkg::S_DIVW:
            begin
                if (d6_cnt_reg == 4'd15)
                    state_next = (idx_reg == 4'd3) ? qrk_pkg::S_SUBCHK : qrk_pkg::S_DIVS;
            end
            qrk_pkg::S_NMUL:   state_next = qrk_pkg::S_NACC;
            qrk_pkg::S_NACC:
                state_next = (idx_reg == 4'd3) ? qrk_pkg::S_SQS : qrk_pkg::S_NMUL;
            qrk_pkg::S_SQS:    state_next = qrk_pkg::S_SQW;
            qrk_pkg::S_SQW:
            begin
                if (sqrt_done)
                    state_next = (sqrt_root == 32'd0) ? qrk_pkg::S_DONE : qrk_pkg::S_ODIVS;
            end
            qrk_pkg::S_ODIVS:  state_next = qrk_pkg::S_ODIVW;
            qrk_pkg::S_ODIVW:
            begin
                if (div_rsp.done)
                    state_next = (idx_reg == 4'd3) ? qrk_pkg::S_DONE : qrk_pkg::S_ODIVS;
            end
            qrk_pkg::S_DONE:   if (out_free) state_next = qrk_pkg::S_IDLE;
            default:           state_next = qrk_pkg::S_IDLE;
        endcase
    end

    // shared unit operands
    always_comb
    begin
        mul_a       = '0;
        mul_b       = '0;
        div_req     = '0;
        sqrt_start  = 1'b0;
        sqrt_x      = n2_reg[64] ? 64'hffff_ffff_ffff_ffff : n2_reg[63:0];
        case (state_reg)
            qrk_pkg::S_HMUL:
            begin
                mul_a = {9'd0, step_reg};
                mul_b = {rate_reg[idx_reg[1:0]][31], rate_reg[idx_reg[1:0]]};
            end
            qrk_pkg::S_DMUL:
            begin
                mul_a = {t_reg[qrk_pkg::term_y(idx_reg)][31], t_reg[qrk_pkg::term_y(idx_reg)]};
                mul_b = hw_reg[qrk_pkg::term_w(idx_reg)];
            end
            qrk_pkg::S_NMUL:
            begin
                mul_a = {q_reg[cidx][31], q_reg[cidx]};
                mul_b = {q_reg[cidx][31], q_reg[cidx]};
            end
            qrk_pkg::S_ODIVS:
            begin
                div_req.start = 1'b1;
                div_req.num   = ({32'd0, qmag} << (QUAT_FRAC_BITS + 1)) + {32'd0, root_reg};
                div_req.den   = {31'd0, root_reg, 1'b0};
            end
            qrk_pkg::S_SQS:    sqrt_start = 1'b1;
            default:           ;
        endcase
    end

    // datapath
    always_comb
    begin
        idx_next       = idx_reg;
        stage_next     = stage_reg;
        sub_next       = sub_reg;
        step_next      = step_reg;
        count_next     = count_reg;
        q_next         = q_reg;
        t_next         = t_reg;
        rate_next      = rate_reg;
        hw_next        = hw_reg;
        kcur_next      = kcur_reg;
        acc_next       = acc_reg;
        term_next      = term_reg;
        n2_next        = n2_reg;
        root_next      = root_reg;
        res_next       = res_reg;
        zero_next      = zero_reg;
        d6_quo_next    = d6_quo_reg;
        d6_rem_next    = d6_rem_reg;
        d6_cnt_next    = d6_cnt_reg;
        out_s_next     = out_s_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_z_next     = out_z_reg;
        norm_zero_next = norm_zero_reg;
        out_valid_next = out_valid_reg && !out_ready;

        if (cfg_we)
        begin
            if (cfg_index == qrk_pkg::CFG_STEP_SIZE)
                step_next = cfg_data;
            else
                count_next = cfg_data[10:0];
        end

        case (state_reg)
            qrk_pkg::S_IDLE:
            begin
                idx_next     = '0;
                q_next[0]    = quat_s;
                q_next[1]    = quat_x;
                q_next[2]    = quat_y;
                q_next[3]    = quat_z;
                rate_next[0] = rate_x;
                rate_next[1] = rate_y;
                rate_next[2] = rate_z;
                sub_next     = (count_reg > qrk_pkg::MAX_SUBSTEPS) ? qrk_pkg::MAX_SUBSTEPS
                                                                   : count_reg;
            end
            qrk_pkg::S_HRND:
            begin
                hw_next[idx_reg[1:0]] = hw_round[32:0];
                idx_next = (idx_reg == 4'd2) ? 4'd0 : idx_reg + 4'd1;
            end
            qrk_pkg::S_SUBCHK:
            begin
                idx_next   = '0;
                stage_next = '0;
                t_next     = q_reg;
                n2_next    = '0;
                for (int i = 0; i < 4; i++)
                    kcur_next[i] = '0;
            end
            qrk_pkg::S_DRND:   term_next = term_round[63:0];
            qrk_pkg::S_DACC:
            begin
                kcur_next[tsel] = qrk_pkg::term_neg(idx_reg) ? kcur_reg[tsel] - term_reg
                                                             : kcur_reg[tsel] + term_reg;
                idx_next = (idx_reg == qrk_pkg::LAST_TERM) ? 4'd0 : idx_reg + 4'd1;
            end
            qrk_pkg::S_UPD:
            begin
                case (stage_reg)
                    2'd0:
                    begin
                        acc_next[cidx] = kc;
                        t_next[cidx]   = qrk_pkg::sat32(qext + khalf);
                    end
                    2'd1:
                    begin
                        acc_next[cidx] = acc_reg[cidx] + (kc <<< 1);
                        t_next[cidx]   = qrk_pkg::sat32(qext + khalf);
                    end
                    2'd2:
                    begin
                        acc_next[cidx] = acc_reg[cidx] + (kc <<< 1);
                        t_next[cidx]   = qrk_pkg::sat32(qext + kc);
                    end
                    default:
                    begin
                        acc_next[cidx] = acc_reg[cidx] + kc + 64'sd3;
                    end
                endcase
                if (idx_reg == 4'd3)
                begin
                    idx_next   = '0;
                    stage_next = stage_reg + 2'd1;
                    for (int i = 0; i < 4; i++)
                        kcur_next[i] = '0;
                end
                else
                begin
                    idx_next = idx_reg + 4'd1;
                end
            end
            qrk_pkg::S_DIVS:
            begin
                d6_quo_next = acc_reg[cidx][63] ? ~acc_reg[cidx] : acc_reg[cidx];
                d6_rem_next = '0;
                d6_cnt_next = '0;
            end
            qrk_pkg::S_DIVW:
            begin
                d6_quo_next = d6_quo_step;
                d6_rem_next = d6_left[2:0];
                d6_cnt_next = d6_cnt_reg + 4'd1;
                if (d6_cnt_reg == 4'd15)
                begin
                    q_next[cidx] = qrk_pkg::sat32(qext + delta);
                    if (idx_reg == 4'd3)
                    begin
                        idx_next = '0;
                        sub_next = sub_reg - 11'd1;
                    end
                    else
                    begin
                        idx_next = idx_reg + 4'd1;
                    end
                end
            end
            qrk_pkg::S_NACC:
            begin
                n2_next  = n2_reg + prod[64:0];
                idx_next = (idx_reg == 4'd3) ? 4'd0 : idx_reg + 4'd1;
            end
            qrk_pkg::S_SQW:
            begin
                if (sqrt_done)
                begin
                    root_next = sqrt_root;
                    zero_next = (sqrt_root == 32'd0);
                    idx_next  = '0;
                    for (int i = 0; i < 4; i++)
                        res_next[i] = '0;
                end
            end
            qrk_pkg::S_ODIVW:
            begin
                if (div_rsp.done)
                begin
                    if (q_reg[cidx][31])
                        res_next[cidx] = 32'd0 - qt[31:0];
                    else
                        res_next[cidx] = qt[31] ? 32'h7fff_ffff : qt[31:0];
                    idx_next = (idx_reg == 4'd3) ? 4'd0 : idx_reg + 4'd1;
                end
            end
            qrk_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    out_s_next     = res_reg[0];
                    out_x_next     = res_reg[1];
                    out_y_next     = res_reg[2];
                    out_z_next     = res_reg[3];
                    norm_zero_next = zero_reg;
                    out_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= qrk_pkg::S_IDLE;
            idx_reg       <= '0;
            stage_reg     <= '0;
            sub_reg       <= '0;
            step_reg      <= qrk_pkg::STEP_SIZE_RESET;
            count_reg     <= qrk_pkg::SUBSTEP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            stage_reg     <= stage_next;
            sub_reg       <= sub_next;
            step_reg      <= step_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg         <= q_next;
        t_reg         <= t_next;
        rate_reg      <= rate_next;
        hw_reg        <= hw_next;
        kcur_reg      <= kcur_next;
        acc_reg       <= acc_next;
        term_reg      <= term_next;
        n2_reg        <= n2_next;
        root_reg      <= root_next;
        res_reg       <= res_next;
        zero_reg      <= zero_next;
        d6_quo_reg    <= d6_quo_next;
        d6_rem_reg    <= d6_rem_next;
        d6_cnt_reg    <= d6_cnt_next;
        out_s_reg     <= out_s_next;
        out_x_reg     <= out_x_next;
        out_y_reg     <= out_y_next;
        out_z_reg     <= out_z_next;
        norm_zero_reg <= norm_zero_next;
    end

    assign in_ready  = (state_reg == qrk_pkg::S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_s     = out_s_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign out_z     = out_z_reg;
    assign norm_zero = norm_zero_reg;

endmodule

### rtl/qrk_checker.sv
// port-level assertions for the quaternion rk4 propagator, bound to the top level
`timescale 1ns / 1ps
module qrk_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [31:0] out_s,
    input logic signed [31:0] out_x,
    input logic signed [31:0] out_y,
    input logic signed [31:0] out_z,
    input logic               norm_zero
);

    // a held result does not change
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_s) && $stable(out_x)
            && $stable(out_y) && $stable(out_z) && $stable(norm_zero))
        else $error("held result changed");

    // busy after a transaction is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready right after accept");

    // zero norm gives a zero quaternion
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && norm_zero |-> out_s == 0 && out_x == 0 && out_y == 0 && out_z == 0)
        else $error("zero norm with nonzero output");

    // a normalized result is never all zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !norm_zero |-> out_s != 0 || out_x != 0 || out_y != 0 || out_z != 0)
        else $error("normalized output all zero");

    // a new result only appears while the block is busy
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result without work");

endmodule

bind quaternion_rk4_propagator_core qrk_checker u_qrk_checker (.*);
